// ===== hdl/sorted_table_linear_interpolator_macros.svh =====
// Assertion macros shared by the interpolator checkers.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Check a same-cycle implication, sampled on clk, off during rst.
`define STI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interpolator port check failed");

// Check an implication in the next cycle, sampled on clk, off during rst.
`define STI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interpolator port check failed");

`endif

// ===== hdl/sti_pkg.sv =====
// Types and constants shared by the interpolator modules.
package sti_pkg;

  // Widths fixed by the item fields
  localparam int CNT_W      = 11;
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Scale-divide unit: one quotient digit (0, 1 or 2) per step
  localparam int DIV_STEPS  = 32;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STATUS_EXACT     = 3'd0,
    STATUS_INTERP    = 3'd1,
    STATUS_PAST_END  = 3'd2,
    STATUS_EXHAUSTED = 3'd3,
    STATUS_ORDER_ERR = 3'd4
  } status_t;

  // Register index taken from the word address
  typedef enum logic [0:0] {
    REG_POINTS_IN_USE = 1'b0
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TEST,
    ST_FETCH_PREV,
    ST_SETUP,
    ST_DIVIDE
  } state_t;

  // Request to the scale-divide unit: quot = floor(mag * t / dx), t < dx
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] dx;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/sti_scale_div.sv =====
// Bit-serial unit that computes floor(mag * t / dx) for t < dx.
module sti_scale_div (
  input  logic             clk,
  input  logic             rst,
  input  sti_pkg::div_req_t req,
  output sti_pkg::div_rsp_t rsp
);

  localparam int DW = sti_pkg::DATA_W;
  localparam int SW = sti_pkg::DIV_STEP_W;
  localparam logic [SW-1:0] STEP_LAST = SW'(sti_pkg::DIV_STEPS - 1);

  logic          running;
  logic          done;
  logic [SW-1:0] step;
  logic [DW-1:0] mag_sh;
  logic [DW-1:0] t;
  logic [DW-1:0] dx;
  logic [DW-1:0] rem;
  logic [DW-1:0] quot;

  logic [DW+1:0] sum;
  logic [DW+1:0] dx1;
  logic [DW+1:0] dx2;
  logic [DW+1:0] sum_left;
  logic [1:0]    digit;
  logic [DW-1:0] rem_next;
  logic [DW-1:0] quot_next;

  // One step: rem*2 + bit*t lies below 3*dx, so the quotient digit is 0, 1 or 2
  always_comb begin
    sum = {1'b0, rem, 1'b0} + (mag_sh[DW-1] ? {2'b00, t} : '0);
    dx1 = {2'b00, dx};
    dx2 = {1'b0, dx, 1'b0};
    if (sum >= dx2) begin
      digit    = 2'd2;
      sum_left = sum - dx2;
    end else if (sum >= dx1) begin
      digit    = 2'd1;
      sum_left = sum - dx1;
    end else begin
      digit    = 2'd0;
      sum_left = sum;
    end
    rem_next  = sum_left[DW-1:0];
    quot_next = {quot[DW-2:0], 1'b0} + DW'(digit);
  end

  // Sequence the steps and pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= STEP_LAST;
      end else if (running) begin
        step <= step - SW'(1);
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Hold operands and advance remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      mag_sh <= req.mag;
      t      <= req.t;
      dx     <= req.dx;
      rem    <= '0;
      quot   <= '0;
    end else if (running) begin
      mag_sh <= {mag_sh[DW-2:0], 1'b0};
      rem    <= rem_next;
      quot   <= quot_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== hdl/sorted_table_linear_interpolator.sv =====
// Top level: breakpoint table, cursor walk sequencer and result register.
//
//  channel  | direction | transfer when            | payload
//  ---------+-----------+--------------------------+-------------------------------------
//  item     | in        | start && !busy           | opcode point_index point_x point_y query_x
//  result   | out       | done (one cycle)         | value status
//  config   | in/out    | psel penable pwrite      | paddr pwdata prdata
//
// A load is complete when accepted and never raises busy. A query on an
// exhausted cursor answers in the next cycle without raising busy. Otherwise
// a query does a table read (FETCH), then a compare (TEST), per breakpoint
// walked; an interpolation adds FETCH_PREV and SETUP for the earlier one and
// DIVIDE for the bit-serial scale-divide unit. Reset clears the cursor and sets
// the point count to 2; the table is not cleared. Results cannot be held off.
module sorted_table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic [9:0]                          point_index,
  input  logic [31:0]                         point_x,
  input  logic signed [31:0]                  point_y,
  input  logic [31:0]                         query_x,
  // result channel
  output logic                                done,
  output logic signed [31:0]                  value,
  output logic [2:0]                          status,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sti_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [sti_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sti_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int CNT_W = sti_pkg::CNT_W;
  localparam int DW    = sti_pkg::DATA_W;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_CAP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
  localparam logic [CNT_W-1:0] CNT_CAP_V = CNT_W'(CNT_CAP);
  localparam logic [CNT_W-1:0] POINTS_RESET = CNT_W'(2);

  sti_pkg::state_t state;
  sti_pkg::state_t state_next;

  logic [CNT_W-1:0] points_in_use;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] cursor_next;
  logic [CNT_W-1:0] walk;
  logic [CNT_W-1:0] walk_next;
  logic [CNT_W-1:0] walk_inc;
  logic [CNT_W-1:0] count;
  logic [DW-1:0]    qx;
  logic [DW-1:0]    qx_next;
  logic [DW-1:0]    x_hi;
  logic [DW-1:0]    x_hi_next;
  logic [DW-1:0]    y_hi;
  logic [DW-1:0]    y_hi_next;
  logic [DW-1:0]    y_lo;
  logic [DW-1:0]    y_lo_next;
  logic             neg;
  logic             neg_next;
  logic             done_next;
  logic [DW-1:0]    value_next;
  sti_pkg::status_t status_reg;
  sti_pkg::status_t status_next;

  logic             accept;
  logic             cfg_write;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [DW-1:0]    x_rd;
  logic [DW-1:0]    y_rd;

  logic signed [DW:0] dy;
  logic [DW+1:0]      blend;

  sti_pkg::div_req_t div_req;
  sti_pkg::div_rsp_t div_rsp;

  logic [DW-1:0] x_mem [TABLE_DEPTH];
  logic [DW-1:0] y_mem [TABLE_DEPTH];

  assign accept    = start && !busy;
  assign busy      = (state != sti_pkg::ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign count     = (points_in_use > CNT_CAP_V) ? CNT_CAP_V : points_in_use;
  assign walk_inc  = walk + CNT_W'(1);

  // Configuration register write and read back
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= POINTS_RESET;
    end else if (cfg_write) begin
      case (paddr[sti_pkg::CFG_ADDR_W-1])
        sti_pkg::REG_POINTS_IN_USE: points_in_use <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[sti_pkg::CFG_ADDR_W-1])
      sti_pkg::REG_POINTS_IN_USE: prdata = sti_pkg::CFG_DATA_W'(points_in_use);
      default:                    prdata = '0;
    endcase
  end

  // Breakpoint table: written by loads, one registered read a cycle
  assign mem_we  = accept && (opcode == sti_pkg::OP_LOAD)
                   && (32'(point_index) < TABLE_DEPTH);
  assign wr_addr = AW'(point_index);
  assign rd_addr = (state == sti_pkg::ST_FETCH) ? AW'(walk) : AW'(walk - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[wr_addr] <= point_x;
      y_mem[wr_addr] <= point_y;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  // Interpolation operands from the bracketing breakpoints
  always_comb begin
    dy = $signed({y_hi[DW-1], y_hi}) - $signed({y_rd[DW-1], y_rd});
    div_req.start = (state == sti_pkg::ST_SETUP);
    div_req.mag   = dy[DW] ? DW'(-dy) : DW'(dy);
    div_req.t     = qx - x_rd;
    div_req.dx    = x_hi - x_rd;
    blend = neg ? ({{2{y_lo[DW-1]}}, y_lo} - {2'b00, div_rsp.quot})
                : ({{2{y_lo[DW-1]}}, y_lo} + {2'b00, div_rsp.quot});
  end

  sti_scale_div u_scale_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer: next state, cursor walk and result
  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    walk_next   = walk;
    qx_next     = qx;
    x_hi_next   = x_hi;
    y_hi_next   = y_hi;
    y_lo_next   = y_lo;
    neg_next    = neg;
    done_next   = 1'b0;
    value_next  = value;
    status_next = status_reg;
    case (state)
      sti_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode == sti_pkg::OP_LOAD) begin
            cursor_next = '0;
          end else if (cursor >= count) begin
            done_next   = 1'b1;
            value_next  = '0;
            status_next = sti_pkg::STATUS_EXHAUSTED;
          end else begin
            qx_next    = query_x;
            walk_next  = cursor;
            state_next = sti_pkg::ST_FETCH;
          end
        end
      end
      sti_pkg::ST_FETCH: begin
        state_next = sti_pkg::ST_TEST;
      end
      sti_pkg::ST_TEST: begin
        if ((walk == cursor) && (x_rd > qx)) begin
          done_next   = 1'b1;
          value_next  = '0;
          status_next = sti_pkg::STATUS_ORDER_ERR;
          state_next  = sti_pkg::ST_IDLE;
        end else if (x_rd < qx) begin
          walk_next = walk_inc;
          if (walk_inc >= count) begin
            // Beyond the last breakpoint: its y was read this pass
            cursor_next = walk_inc;
            done_next   = 1'b1;
            value_next  = y_rd;
            status_next = sti_pkg::STATUS_PAST_END;
            state_next  = sti_pkg::ST_IDLE;
          end else begin
            state_next = sti_pkg::ST_FETCH;
          end
        end else if (x_rd == qx) begin
          cursor_next = walk;
          done_next   = 1'b1;
          value_next  = y_rd;
          status_next = sti_pkg::STATUS_EXACT;
          state_next  = sti_pkg::ST_IDLE;
        end else begin
          x_hi_next  = x_rd;
          y_hi_next  = y_rd;
          state_next = sti_pkg::ST_FETCH_PREV;
        end
      end
      sti_pkg::ST_FETCH_PREV: begin
        state_next = sti_pkg::ST_SETUP;
      end
      sti_pkg::ST_SETUP: begin
        y_lo_next  = y_rd;
        neg_next   = dy[DW];
        state_next = sti_pkg::ST_DIVIDE;
      end
      sti_pkg::ST_DIVIDE: begin
        if (div_rsp.done) begin
          cursor_next = walk - CNT_W'(1);
          done_next   = 1'b1;
          status_next = sti_pkg::STATUS_INTERP;
          state_next  = sti_pkg::ST_IDLE;
          // Saturate the blended value to 32 bits
          if ((blend[DW+1:DW-1] == 3'b000) || (blend[DW+1:DW-1] == 3'b111)) begin
            value_next = blend[DW-1:0];
          end else if (blend[DW+1]) begin
            value_next = sti_pkg::VALUE_MIN;
          end else begin
            value_next = sti_pkg::VALUE_MAX;
          end
        end
      end
      default: begin
        state_next = sti_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sti_pkg::ST_IDLE;
      cursor <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      done   <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    walk       <= walk_next;
    qx         <= qx_next;
    x_hi       <= x_hi_next;
    y_hi       <= y_hi_next;
    y_lo       <= y_lo_next;
    neg        <= neg_next;
    value      <= value_next;
    status_reg <= status_next;
  end

  assign status = status_reg;

endmodule

// ===== hdl/sti_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
`include "sorted_table_linear_interpolator_macros.svh"

module sti_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               opcode,
  input logic               done,
  input logic signed [31:0] value,
  input logic [2:0]         status
);

  // A result follows either a query under way or a transfer just taken
  `STI_ASSERT_NOW(a_result_has_cause, done, $past(busy) || $past(start && !busy))

  // Leaving the busy phase always delivers a result
  `STI_ASSERT_NOW(a_busy_end_delivers, $fell(busy), done)

  // A load never produces a result
  `STI_ASSERT_NEXT(a_load_silent, start && !busy && (opcode == sti_pkg::OP_LOAD), !done)

  // A query either starts work or answers at once
  `STI_ASSERT_NEXT(a_query_progress, start && !busy && (opcode == sti_pkg::OP_QUERY),
                   busy || done)

  // Exhausted and order-error results carry a zero value
  `STI_ASSERT_NOW(a_flag_zero_value,
                  done && ((status == sti_pkg::STATUS_EXHAUSTED)
                           || (status == sti_pkg::STATUS_ORDER_ERR)),
                  value == 32'sd0)

endmodule

bind sorted_table_linear_interpolator sti_checker u_sti_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .done   (done),
  .value  (value),
  .status (status)
);
